FILE: hw/rtl/circular_fifo_with_search_unit_assert.svh
// Assertion helpers; expect clk and rst_n in scope.
`ifndef CIRCULAR_FIFO_WITH_SEARCH_UNIT_ASSERT_SVH
`define CIRCULAR_FIFO_WITH_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CFWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CFWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cfws_pkg.sv
package cfws_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W   = 3;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CAP_RST = CFG_W'(16);

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ    = OP_W'(0);
  localparam logic [OP_W-1:0] OP_DEQ    = OP_W'(1);
  localparam logic [OP_W-1:0] OP_PEEK   = OP_W'(2);
  localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(3);
  localparam logic [OP_W-1:0] OP_SEARCH = OP_W'(4);

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = STAT_W'(0);
  localparam logic [STAT_W-1:0] STAT_FULL     = STAT_W'(1);
  localparam logic [STAT_W-1:0] STAT_EMPTY    = STAT_W'(2);
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = STAT_W'(3);

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data_out;
    logic [SLOT_W-1:0]        slot_index;
    logic [POS_W-1:0]         logical_position;
    logic [CNT_W-1:0]         item_count;
    logic                     is_full;
    logic                     is_empty;
  } out_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic wr_en;       // store data into this slot
    logic srch_start;  // latch compare against key, load token
    logic tok_set;     // token start value (head slot)
    logic scan_en;     // advance token one hop
  } cell_ctl_t;

endpackage

FILE: hw/rtl/circular_fifo_with_search_unit.sv
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data   (in_t: operation, data_in)
// out_     output     out_valid/out_stall out_data  (out_t: status .. is_empty)
// cfg_     input      cfg_wr_en           cfg_wr_data (capacity_in_use)
//
// Enqueue, dequeue, peek, clear and unused codes: the result is in the output
// register after the accepting edge.
// Search: the scan token moves one cell of the slot chain per cycle from the head until
// a match or the last entry, and waits there for a free output. An empty queue answers at once.
// Reset (rst_n, synchronous): pointers and count to 0, capacity to 16; slot words
// are not cleared.
// A stalled output holds its result; a new item is taken only when the output
// register is free or is transferring in the same cycle.
`include "circular_fifo_with_search_unit_assert.svh"

module circular_fifo_with_search_unit
  import cfws_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  // capacity register
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  // pointer width, count width, and a compare width wide enough for all of them
  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int MW0 = (PW > CW) ? PW : CW;
  localparam int MW1 = (MW0 > CFG_W) ? MW0 : CFG_W;
  localparam int NW  = MW1 + 1;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Wrap rule: step to slot 0 once the next value reaches the active capacity.
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p,
                                             input logic [NW-1:0] cap);
    logic [NW-1:0] n;
    n = NW'(p) + NW'(1);
    return (n >= cap) ? '0 : PW'(n);
  endfunction

  state_t           state_r, state_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [PW-1:0]    scan_p_r, scan_p_nxt;
  logic [CW-1:0]    scan_i_r, scan_i_nxt;
  logic [CFG_W-1:0] cap_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  logic [NW-1:0]    eff_cap;
  logic [NW-1:0]    count_ext;
  logic             in_acc;
  logic             out_free;
  logic             enq_do;
  logic             srch_go;
  logic             scan_adv;
  logic             ld_out;
  logic             hit_any;
  logic             scan_last;
  logic             wrap;
  out_t             res;

  // slot chain wiring
  cell_ctl_t                ctl_vec  [DEPTH];
  logic signed [DATA_W-1:0] word_vec [DEPTH];
  logic [DEPTH-1:0]         tok_vec;
  logic [DEPTH-1:0]         tok_in;
  logic [DEPTH-1:0]         hit_vec;

  // Capacity register; write only while idle (the user is bound, the block does not enforce it).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Zero acts as one, anything above the slot count acts as the slot count.
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = NW'(1);
    end else if (NW'(cap_r) > NW'(DEPTH)) begin
      eff_cap = NW'(DEPTH);
    end else begin
      eff_cap = NW'(cap_r);
    end
  end

  assign count_ext = NW'(count_r);

  // Output register frees up when empty or when its transfer completes now.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign hit_any   = |hit_vec;
  assign scan_last = (NW'(scan_i_r) + NW'(1)) >= count_ext;

  // Token hop: cell i takes it from cell i-1 while i is inside the capacity;
  // cell 0 takes it from any cell whose successor would wrap.
  always_comb begin
    wrap = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if ((NW'(j) + NW'(1)) >= eff_cap) begin
        wrap = wrap | tok_vec[j];
      end
    end
    tok_in[0] = wrap;
    for (int i = 1; i < DEPTH; i++) begin
      tok_in[i] = tok_vec[i-1] & (NW'(i) < eff_cap);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl_vec[i].wr_en      = enq_do && (tail_r == PW'(i));
      ctl_vec[i].srch_start = srch_go;
      ctl_vec[i].tok_set    = (head_r == PW'(i));
      ctl_vec[i].scan_en    = scan_adv;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cfws_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_vec[g]),
      .data_i (in_data.data_in),
      .tok_i  (tok_in[g]),
      .word_o (word_vec[g]),
      .tok_o  (tok_vec[g]),
      .hit_o  (hit_vec[g])
    );
  end

  // Sequencer: other ops complete at the accepting edge, a search on a non-empty queue scans.
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    scan_p_nxt = scan_p_r;
    scan_i_nxt = scan_i_r;
    enq_do     = 1'b0;
    srch_go    = 1'b0;
    scan_adv   = 1'b0;
    ld_out     = 1'b0;
    res        = '0;
    res.status = STAT_OK;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ld_out = 1'b1;
          case (in_data.operation)
            OP_ENQ: begin
              if (count_ext >= eff_cap) begin
                res.status = STAT_FULL;
              end else begin
                enq_do    = 1'b1;
                tail_nxt  = next_ptr(tail_r, eff_cap);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (count_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                res.data_out = word_vec[head_r];
                if (in_data.operation == OP_DEQ) begin
                  head_nxt  = next_ptr(head_r, eff_cap);
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                res.status = STAT_NOTFOUND;
              end else begin
                // result comes from the scan
                ld_out     = 1'b0;
                srch_go    = 1'b1;
                scan_p_nxt = head_r;
                scan_i_nxt = '0;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              // unused codes: no change, status ok
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit_any || scan_last) begin
          // hold the token until the output register can take the result
          if (out_free) begin
            ld_out    = 1'b1;
            state_nxt = S_IDLE;
            if (hit_any) begin
              res.slot_index       = SLOT_W'(scan_p_r);
              res.logical_position = POS_W'(scan_i_r);
            end else begin
              res.status = STAT_NOTFOUND;
            end
          end
        end else begin
          scan_adv   = 1'b1;
          scan_p_nxt = next_ptr(scan_p_r, eff_cap);
          scan_i_nxt = scan_i_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.item_count = CNT_W'(count_nxt);
    res.is_full    = NW'(count_nxt) >= eff_cap;
    res.is_empty   = (count_nxt == '0);
  end

  assign out_valid_nxt = ld_out || (out_valid_r && out_stall);
  assign out_nxt       = ld_out ? res : out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      scan_p_r    <= '0;
      scan_i_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      scan_p_r    <= scan_p_nxt;
      scan_i_r    <= scan_i_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // exactly one cell carries the scan token
  `CFWS_ASSERT_IMP(a_tok_onehot, state_r == S_SCAN, $onehot(tok_vec), "scan token not one-hot")
  // token position tracks the binary scan pointer
  `CFWS_ASSERT_IMP(a_tok_at_ptr, state_r == S_SCAN, tok_vec[scan_p_r], "token off scan pointer")
  // scan never walks past the held entries
  `CFWS_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, scan_i_r < count_r, "scan past entry count")
  // a search on a non-empty queue enters the scan
  `CFWS_ASSERT_NXT(a_srch_enter, in_acc && (in_data.operation == OP_SEARCH) && (count_r != '0), state_r == S_SCAN, "search did not start scan")

endmodule

FILE: hw/rtl/cfws_cell.sv
module cfws_cell
  import cfws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic                     tok_i,
  output logic signed [DATA_W-1:0] word_o,
  output logic                     tok_o,
  output logic                     hit_o
);

  logic signed [DATA_W-1:0] word_r;
  logic                     match_r;
  logic                     tok_r;
  logic                     tok_nxt;

  always_comb begin
    tok_nxt = tok_r;
    if (ctl_i.srch_start) begin
      tok_nxt = ctl_i.tok_set;
    end else if (ctl_i.scan_en) begin
      tok_nxt = tok_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // slot word and compare flag: payload, no reset
  always_ff @(posedge clk) begin
    if (ctl_i.wr_en) begin
      word_r <= data_i;
    end
    if (ctl_i.srch_start) begin
      match_r <= (word_r == data_i);
    end
  end

  assign word_o = word_r;
  assign tok_o  = tok_r;
  assign hit_o  = tok_r & match_r;

endmodule

FILE: dv/circular_fifo_with_search_unit_tb.sv
`timescale 1ns / 1ps

module circular_fifo_with_search_unit_tb;
  import cfws_pkg::*;

  localparam int SLOTS     = DEPTH_DEF;
  localparam int HOLD_LEN  = 150;    // long receiver hold-off, in cycles
  localparam int TAIL_WAIT = 40;     // longer than the longest search, plus margin

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_t              in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_t             out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  circular_fifo_with_search_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the queue: capacity register, slot words, pointers, count
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]         cap_shadow = CAP_RST;
  logic signed [DATA_W-1:0] slot_shadow [SLOTS];
  int                       head_shadow  = 0;
  int                       tail_shadow  = 0;
  int                       count_shadow = 0;

  out_t pending_results [$];   // expected results, oldest first
  int   err_count = 0;

  // Idle knobs, percent chance per transfer / per cycle
  int gap_pct   = 0;
  int stall_pct = 0;
  bit offering  = 1'b0;        // mirrors the last value put on in_valid
  bit hold_request = 1'b0;     // asks the receiver for one long hold-off

  // Capacity as the queue sees it: 0 acts as 1, above DEPTH acts as DEPTH
  function automatic int eff_capacity();
    if (cap_shadow == 0) return 1;
    if (cap_shadow > SLOTS) return SLOTS;
    return int'(cap_shadow);
  endfunction

  // Pointer step: wraps to slot 0 once it would reach the capacity
  function automatic int ring_step(int p, int cap);
    return (p + 1 >= cap) ? 0 : p + 1;
  endfunction

  // Applies one request to the shadow queue and returns the result it gives
  function automatic out_t fifo_predict(in_t req);
    out_t res;
    int   cap;
    int   p;
    bit   hit;
    cap = eff_capacity();
    res = '0;
    res.status = STAT_OK;
    case (req.operation)
      OP_ENQ: begin
        if (count_shadow >= cap) begin
          res.status = STAT_FULL;
        end else begin
          slot_shadow[tail_shadow] = req.data_in;
          tail_shadow = ring_step(tail_shadow, cap);
          count_shadow++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (count_shadow == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data_out = slot_shadow[head_shadow];
          if (req.operation == OP_DEQ) begin
            head_shadow = ring_step(head_shadow, cap);
            count_shadow--;
          end
        end
      end
      OP_CLEAR: begin
        head_shadow  = 0;
        tail_shadow  = 0;
        count_shadow = 0;
      end
      OP_SEARCH: begin
        // oldest to newest, first match wins
        p   = head_shadow;
        hit = 1'b0;
        for (int i = 0; i < count_shadow && !hit; i++) begin
          if (slot_shadow[p] == req.data_in) begin
            hit = 1'b1;
            res.slot_index       = SLOT_W'(p);
            res.logical_position = POS_W'(i);
          end else begin
            p = ring_step(p, cap);
          end
        end
        if (!hit) res.status = STAT_NOTFOUND;
      end
      default: ;   // codes 5..7 leave the queue alone
    endcase
    res.item_count = CNT_W'(count_shadow);
    res.is_full    = (count_shadow >= cap);
    res.is_empty   = (count_shadow == 0);
    return res;
  endfunction

  // A word currently held, picked at a random distance from the head
  function automatic logic signed [DATA_W-1:0] held_word();
    int p;
    int k;
    p = head_shadow;
    k = $urandom_range(0, count_shadow - 1);
    repeat (k) p = ring_step(p, eff_capacity());
    return slot_shadow[p];
  endfunction

  // Mostly full-range random; sometimes a small pool so duplicates show up
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return DATA_W'($urandom_range(0, 3)) - 1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transfer per call, optional random gap ahead of it.
  // in_valid stays high between back-to-back transfers.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] word);
    in_t req;
    req.operation = op;
    req.data_in   = word;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering  = 1'b0;
      end
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    offering  = 1'b1;
    do @(posedge clk); while (in_stall);
    // accepted at this edge
    pending_results.push_back(fifo_predict(req));
  endtask

  // Stop offering and wait until every expected result has been seen
  task automatic drain_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering  = 1'b0;
    end
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  // Capacity write; only called with the block idle
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    cap_shadow  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off
  // counted here on request.
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request || hold_left > 0) begin
      if (hold_request) begin
        hold_left    = HOLD_LEN;
        hold_request = 1'b0;
      end
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      burst_left  = $urandom_range(1, 5) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every result transfer is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  out_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          err_count++;
        end
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %0d, actual %0d", want.data_out, out_data.data_out);
          err_count++;
        end
        if (out_data.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d",
                 want.slot_index, out_data.slot_index);
          err_count++;
        end
        if (out_data.logical_position !== want.logical_position) begin
          $error("logical_position: expected %0d, actual %0d",
                 want.logical_position, out_data.logical_position);
          err_count++;
        end
        if (out_data.item_count !== want.item_count) begin
          $error("item_count: expected %0d, actual %0d",
                 want.item_count, out_data.item_count);
          err_count++;
        end
        if (out_data.is_full !== want.is_full) begin
          $error("is_full: expected %0d, actual %0d", want.is_full, out_data.is_full);
          err_count++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, out_data.is_empty);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Refusals and misses on an empty queue, and the unused codes
  task automatic test_empty_queue();
    send_item(OP_DEQ, 32'sd5);
    send_item(OP_PEEK, -32'sd1);
    send_item(OP_SEARCH, 32'sd0);
    send_item(3'd5, 32'sh7FFF_FFFF);
    send_item(3'd6, 32'sh8000_0000);
    send_item(3'd7, -32'sd1);
  endtask

  // Fill every slot (so no later read can hit an unwritten slot), then
  // refusal on full, search hits at both ends, first of two duplicates, a miss
  task automatic test_fill_and_full();
    send_item(OP_ENQ, 32'sh8000_0000);
    send_item(OP_ENQ, 32'sh7FFF_FFFF);
    send_item(OP_ENQ, 32'sd0);
    send_item(OP_ENQ, -32'sd1);
    for (int i = 4; i < SLOTS - 1; i++) send_item(OP_ENQ, DATA_W'((i - 4) * 111111));
    send_item(OP_ENQ, 32'sh5A5A_5A5A);
    send_item(OP_ENQ, 32'sd77);           // full: refused
    send_item(OP_PEEK, 32'sd0);
    send_item(OP_SEARCH, 32'sh8000_0000); // head
    send_item(OP_SEARCH, 32'sh5A5A_5A5A); // tail
    send_item(OP_SEARCH, 32'sd0);         // duplicate: first one wins
    send_item(OP_SEARCH, 32'sd99);        // miss
    send_item(OP_DEQ, 32'sd0);
    send_item(OP_CLEAR, 32'sd0);
    drain_results();
  endtask

  // Receiver holds off while requests keep coming: the output register
  // fills and the input must stall until the hold-off ends
  task automatic test_backpressure();
    gap_pct      = 0;
    stall_pct    = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2 && count_shadow > 0) send_item(OP_SEARCH, held_word());
      else send_item(OP_ENQ, pick_word());
    end
    drain_results();
  endtask

  // Mixed traffic; searches mostly look for a word that is held
  task automatic test_random_traffic(input int n_items, input int gap_v, input int stall_v);
    int r;
    gap_pct   = gap_v;
    stall_pct = stall_v;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        send_item(OP_ENQ, pick_word());
      end else if (r < 60) begin
        send_item(OP_DEQ, $urandom);
      end else if (r < 68) begin
        send_item(OP_PEEK, $urandom);
      end else if (r < 94) begin
        if (count_shadow > 0 && $urandom_range(0, 9) < 7) send_item(OP_SEARCH, held_word());
        else send_item(OP_SEARCH, pick_word());
      end else if (r < 96) begin
        send_item(OP_CLEAR, $urandom);
      end else begin
        send_item(OP_W'($urandom_range(5, 7)), $urandom);
      end
    end
    drain_results();
  endtask

  // Capacity settings, extremes included; entries are kept across the
  // changes, so the capacity often moves while the queue holds words
  task automatic test_capacity_sweep();
    logic [CFG_W-1:0] caps [8];
    caps = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd17, 5'd9, 5'd16};
    caps[7] = CFG_W'($urandom_range(0, 31));
    foreach (caps[k]) begin
      write_capacity(caps[k]);
      // every other phase runs without any idling
      if (k % 2 == 0) test_random_traffic(200, 25, 25);
      else test_random_traffic(200, 0, 0);
    end
  endtask

  // Last stretch: no idling on either side, full capacity
  task automatic test_quiet_tail();
    write_capacity(CAP_RST);
    test_random_traffic(150, 0, 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_fill_and_full();
    test_backpressure();
    test_capacity_sweep();
    test_quiet_tail();
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
